/* hdl/fpm_pkg.sv */
// Package for the binary32 multiplier: field constants and shared types.
// No dependencies.
package fpm_pkg;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned SigW  = 24;
  localparam int unsigned ProdW = 48;
  localparam logic [31:0] DefNan  = 32'h7FC0_0000;
  localparam logic [31:0] InfBits = 32'h7F80_0000;
  localparam logic [31:0] QuietBit = 32'h0040_0000;

  // Operand class after decode.
  typedef struct packed {
    logic        special;    // result fixed, no arithmetic needed
    logic [31:0] special_val;
    logic        sign;
  } fpm_cls_t;

  // Leading-zero count of a 24-bit significand (zero input gives 24).
  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction
endpackage

/* hdl/fpm_round.sv */
// Rounding stage logic of the binary32 multiplier: denormalize shift,
// round to nearest even and pack. Depends on fpm_pkg.
module fpm_round (
  input  logic [47:0] prod,      // leading one at bit 47
  input  logic signed [10:0] exp_in,
  input  logic        sign,
  output logic [31:0] result
);
  import fpm_pkg::*;

  logic [5:0]  sh;
  logic [47:0] p;
  logic        sticky0;
  logic [23:0] kept;
  logic [23:0] rest;
  logic        guard;
  logic        sticky;
  logic [24:0] kept_r;
  logic [31:0] bits;
  logic [47:0] mask;

  always_comb begin
    sh = 6'd0;
    mask = '0;
    if (exp_in <= 0) begin
      if ((11'sd1 - exp_in) >= 11'sd48) sh = 6'd48;
      else sh = 6'((11'sd1 - exp_in));
    end
    if (sh >= 6'd48) begin
      p = '0;
      sticky0 = |prod;
    end else begin
      mask = (48'd1 << sh) - 48'd1;
      sticky0 = |(prod & mask);
      p = prod >> sh;
    end
    kept  = p[47:24];
    rest  = p[23:0];
    guard = rest[23];
    sticky = sticky0 | (|rest[22:0]);
    kept_r = {1'b0, kept} + 25'(guard & (sticky | kept[0]));
    if (exp_in >= 1)
      bits = {exp_in[7:0] - 8'd1, 23'd0} + 32'(kept_r);
    else
      bits = 32'(kept_r);
    if (exp_in >= 11'sd255 || bits >= InfBits) bits = InfBits;
    result = {sign, bits[30:0]};
  end
endmodule

/* hdl/fp32_multiplier.sv */
// Top level of the binary32 multiplier, round to nearest even.
// Accepts one request per cycle while the output is not stalled.
// Pipeline: decode/normalize, 24x24 multiply, normalize product, round/pack.
// Stages advance together and hold under output backpressure (tready low).
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
// Depends on fpm_pkg and fpm_round.
module fp32_multiplier (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] operand_a, [63:32] operand_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] product
);
  import fpm_pkg::*;

  logic adv;
  logic v1, v2, v3, v4;

  // stage 1: unpacked operands
  fpm_cls_t    c1;
  logic [23:0] ma1, mb1;
  logic signed [10:0] e1;
  // stage 2: raw product
  fpm_cls_t    c2;
  logic [47:0] p2;
  logic signed [10:0] e2;
  // stage 3: normalized product
  fpm_cls_t    c3;
  logic [47:0] p3;
  logic signed [10:0] e3;
  // stage 4: output register
  logic [31:0] res4;

  // pipeline moves as a whole unless the output holds a result nobody took
  assign adv = !v4 || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v4;
  assign m_axis_tdata  = res4;

  logic [31:0] a, b;
  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic        az, bz;
  fpm_cls_t    c_next;
  logic [23:0] ma_next, mb_next;
  logic [4:0]  la, lb;
  logic signed [10:0] e_next;

  always_comb begin
    a  = s_axis_tdata[31:0];
    b  = s_axis_tdata[63:32];
    ea = a[30:23]; eb = b[30:23];
    fa = a[22:0];  fb = b[22:0];
    az = (ea == 8'd0) && (fa == 23'd0);
    bz = (eb == 8'd0) && (fb == 23'd0);
    c_next.sign = a[31] ^ b[31];
    c_next.special = 1'b1;
    c_next.special_val = {c_next.sign, 31'd0};
    if (ea == 8'hFF && fa != 23'd0)      c_next.special_val = a | QuietBit;
    else if (eb == 8'hFF && fb != 23'd0) c_next.special_val = b | QuietBit;
    else if (ea == 8'hFF || eb == 8'hFF) begin
      if (az || bz) c_next.special_val = DefNan;
      else          c_next.special_val = {c_next.sign, InfBits[30:0]};
    end else if (az || bz) c_next.special_val = {c_next.sign, 31'd0};
    else c_next.special = 1'b0;
    // subnormals normalized by leading-zero shift
    la = lzc24({1'b0, fa});
    lb = lzc24({1'b0, fb});
    if (ea == 8'd0) ma_next = {1'b0, fa} << (la - 5'd0);
    else            ma_next = {1'b1, fa};
    if (eb == 8'd0) mb_next = {1'b0, fb} << lb;
    else            mb_next = {1'b1, fb};
    e_next = ((ea == 8'd0) ? (11'sd1 - 11'(la)) : 11'(ea))
           + ((eb == 8'd0) ? (11'sd1 - 11'(lb)) : 11'(eb)) - 11'sd127;
  end

  logic [31:0] res_next;
  fpm_round u_round (
    .prod   (p3),
    .exp_in (e3),
    .sign   (c3.sign),
    .result (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (adv) begin
      c1 <= c_next; ma1 <= ma_next; mb1 <= mb_next; e1 <= e_next;
      c2 <= c1; p2 <= ma1 * mb1; e2 <= e1;
      c3 <= c2;
      if (p2[47]) begin
        p3 <= p2;        e3 <= e2 + 11'sd1;
      end else begin
        p3 <= p2 << 1;   e3 <= e2;
      end
      res4 <= c3.special ? c3.special_val : res_next;
    end
  end
endmodule
